// ===== rtl/hamming_31_26_byte_stream_decoder_defines.svh =====
// assertion macros for the hamming byte stream decoder checker
`ifndef HAMMING_31_26_BYTE_STREAM_DECODER_DEFINES_SVH
`define HAMMING_31_26_BYTE_STREAM_DECODER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define HCD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hcd_pkg.sv =====
// shared constants, types and functions of the hamming byte stream decoder
package hcd_pkg;

    localparam int BYTE_W      = 8;
    localparam int CODE_BITS   = 31;
    localparam int DATA_BITS   = 26;
    localparam int MAX_RESULTS = 4;
    localparam int CTR_W       = 32;

    localparam int FILL_W = $clog2(CODE_BITS);
    localparam int SYN_W  = $clog2(CODE_BITS + 1);
    localparam int WORD_W = CODE_BITS + BYTE_W;

    // number of non-parity positions actually packed from one codeword
    function automatic int count_data();
        int n;
        int pos;
        n = 0;
        for (int k = 2; k < CODE_BITS; k++) begin
            pos = k + 1;
            if (((pos & (pos - 1)) != 0) && (n < DATA_BITS)) begin
                n++;
            end
        end
        return n;
    endfunction

    localparam int DATA_TAKEN = count_data();
    localparam int MAX_BYTES  = (DATA_TAKEN + 7) / 8;
    localparam int PACK_W     = BYTE_W * (MAX_BYTES + 1);
    localparam int TOT_W      = $clog2(DATA_TAKEN + 8);
    localparam int NB_W       = $clog2(MAX_BYTES + 1);
    localparam int CNT_W      = $clog2(MAX_RESULTS + 1);

    // bytes released by one codeword, top aligned, plus their shared status
    typedef struct packed {
        logic [PACK_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              corr;
        logic [CTR_W-1:0]  total;
    } t_burst;

    // msb of the received byte is gathered first
    function automatic logic [BYTE_W-1:0] bit_reverse(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int j = 0; j < BYTE_W; j++) begin
            r[j] = b[BYTE_W-1-j];
        end
        return r;
    endfunction

    // xor of the positions of all one bits
    function automatic logic [SYN_W-1:0] syndrome(input logic [CODE_BITS-1:0] cw);
        logic [SYN_W-1:0] s;
        s = '0;
        for (int k = 0; k < CODE_BITS; k++) begin
            if (cw[k]) begin
                s = s ^ SYN_W'(k + 1);
            end
        end
        return s;
    endfunction

    // data bits, lowest position first, placed msb first
    function automatic logic [DATA_TAKEN-1:0] extract_data(input logic [CODE_BITS-1:0] cw);
        logic [DATA_TAKEN-1:0] d;
        int                    n;
        int                    pos;
        d = '0;
        n = 0;
        for (int k = 2; k < CODE_BITS; k++) begin
            pos = k + 1;
            if (((pos & (pos - 1)) != 0) && (n < DATA_TAKEN)) begin
                d[DATA_TAKEN-1-n] = cw[k];
                n++;
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/hcd_core.sv =====
// codeword gathering, syndrome correction and data bit packing
module hcd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [hcd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_packet_end,
    output logic                        o_will_complete,
    output logic                        o_load,
    output hcd_pkg::t_burst             o_burst
);

    logic [hcd_pkg::CODE_BITS-1:0]  r_code_shift, n_code_shift;
    logic [hcd_pkg::FILL_W-1:0]     r_code_fill, n_code_fill;
    logic [hcd_pkg::BYTE_W-1:0]     r_pack_bits, n_pack_bits;
    logic [2:0]                     r_pack_fill, n_pack_fill;
    logic [hcd_pkg::CTR_W-1:0]      r_corr_cnt, n_corr_cnt;

    logic [hcd_pkg::FILL_W:0]       fill_sum;
    logic [hcd_pkg::WORD_W-1:0]     word;
    logic [hcd_pkg::CODE_BITS-1:0]  cw;
    logic [hcd_pkg::CODE_BITS-1:0]  flip_mask;
    logic [hcd_pkg::CODE_BITS-1:0]  cw_fixed;
    logic [hcd_pkg::SYN_W-1:0]      syn;
    logic                           fix;
    logic [hcd_pkg::DATA_TAKEN-1:0] data;
    logic [hcd_pkg::PACK_W-1:0]     combined;
    logic [hcd_pkg::PACK_W-1:0]     leftover;
    logic [hcd_pkg::TOT_W-1:0]      pack_total;
    logic [hcd_pkg::NB_W-1:0]       nbytes;

    // a codeword completes on this byte when the fill reaches the code length
    assign fill_sum        = {1'b0, r_code_fill} + (hcd_pkg::FILL_W + 1)'(hcd_pkg::BYTE_W);
    assign o_will_complete = (fill_sum >= (hcd_pkg::FILL_W + 1)'(hcd_pkg::CODE_BITS));

    // merge new bits behind the gathered ones
    assign word = {{hcd_pkg::BYTE_W{1'b0}}, r_code_shift}
                | (hcd_pkg::WORD_W'(hcd_pkg::bit_reverse(i_rx_byte)) << r_code_fill);
    assign cw   = word[hcd_pkg::CODE_BITS-1:0];

    // single error correction
    assign syn       = hcd_pkg::syndrome(cw);
    assign fix       = (syn != '0) && (syn <= hcd_pkg::SYN_W'(hcd_pkg::CODE_BITS));
    assign flip_mask = hcd_pkg::CODE_BITS'(1) << (syn - hcd_pkg::SYN_W'(1));
    assign cw_fixed  = fix ? (cw ^ flip_mask) : cw;
    assign data      = hcd_pkg::extract_data(cw_fixed);

    // append data bits to the partial output byte
    assign combined = {r_pack_bits, {(hcd_pkg::PACK_W - hcd_pkg::BYTE_W){1'b0}}}
                    | ({data, {(hcd_pkg::PACK_W - hcd_pkg::DATA_TAKEN){1'b0}}} >> r_pack_fill);
    assign pack_total = hcd_pkg::TOT_W'(r_pack_fill) + hcd_pkg::TOT_W'(hcd_pkg::DATA_TAKEN);
    assign nbytes     = hcd_pkg::NB_W'(pack_total >> 3);
    assign leftover   = combined << {nbytes, 3'b000};

    // next state
    always_comb begin
        n_code_shift = r_code_shift;
        n_code_fill  = r_code_fill;
        n_pack_bits  = r_pack_bits;
        n_pack_fill  = r_pack_fill;
        n_corr_cnt   = r_corr_cnt;
        if (i_accept) begin
            if (o_will_complete) begin
                n_code_shift = hcd_pkg::CODE_BITS'(word >> hcd_pkg::CODE_BITS);
                n_code_fill  = hcd_pkg::FILL_W'(fill_sum
                             - (hcd_pkg::FILL_W + 1)'(hcd_pkg::CODE_BITS));
                n_pack_bits  = leftover[hcd_pkg::PACK_W-1 -: hcd_pkg::BYTE_W];
                n_pack_fill  = pack_total[2:0];
                if (fix && (r_corr_cnt != '1)) begin
                    n_corr_cnt = r_corr_cnt + hcd_pkg::CTR_W'(1);
                end
            end else begin
                n_code_shift = cw;
                n_code_fill  = hcd_pkg::FILL_W'(fill_sum);
            end
            if (i_packet_end) begin
                n_code_shift = '0;
                n_code_fill  = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_shift <= '0;
            r_code_fill  <= '0;
            r_pack_bits  <= '0;
            r_pack_fill  <= '0;
            r_corr_cnt   <= '0;
        end else begin
            r_code_shift <= n_code_shift;
            r_code_fill  <= n_code_fill;
            r_pack_bits  <= n_pack_bits;
            r_pack_fill  <= n_pack_fill;
            r_corr_cnt   <= n_corr_cnt;
        end
    end

    // burst handed to the output buffer
    assign o_load        = i_accept && o_will_complete;
    assign o_burst.data  = combined;
    assign o_burst.count = (nbytes > hcd_pkg::NB_W'(hcd_pkg::MAX_RESULTS))
                         ? hcd_pkg::CNT_W'(hcd_pkg::MAX_RESULTS)
                         : hcd_pkg::CNT_W'(nbytes);
    assign o_burst.corr  = fix;
    assign o_burst.total = n_corr_cnt;

endmodule

// ===== rtl/hcd_out_buf.sv =====
// result register that releases a codeword's bytes one per transfer
module hcd_out_buf (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  hcd_pkg::t_burst                     i_burst,
    output logic                                o_free,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [hcd_pkg::BYTE_W-1:0]          o_out_byte,
    output logic                                o_frame_corrected,
    output logic [hcd_pkg::CTR_W-1:0]           o_correction_total,
    output logic                                o_last_of_run
);

    logic [hcd_pkg::PACK_W-1:0] r_data;
    logic [hcd_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_corr;
    logic [hcd_pkg::CTR_W-1:0]  r_total;
    logic                       take;

    assign take   = o_out_valid && i_out_ready;
    // empty now, or the last byte leaves this cycle
    assign o_free = (r_cnt == '0) || ((r_cnt == hcd_pkg::CNT_W'(1)) && i_out_ready);

    // byte count is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - hcd_pkg::CNT_W'(1);
        end
    end

    // payload shifts up one byte per transfer
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data  <= i_burst.data;
            r_corr  <= i_burst.corr;
            r_total <= i_burst.total;
        end else if (take) begin
            r_data  <= r_data << hcd_pkg::BYTE_W;
        end
    end

    assign o_out_valid        = (r_cnt != '0);
    assign o_out_byte         = r_data[hcd_pkg::PACK_W-1 -: hcd_pkg::BYTE_W];
    assign o_frame_corrected  = r_corr;
    assign o_correction_total = r_total;
    assign o_last_of_run      = (r_cnt == hcd_pkg::CNT_W'(1));

endmodule

// ===== rtl/hamming_31_26_byte_stream_decoder.sv =====
// top level of the hamming (31,26) byte stream decoder
// a byte that completes a codeword shows its first decoded byte in the next cycle
// throughput: one received byte per cycle; a completed codeword then releases 3 or 4
// bytes at one per cycle from the result register while i_out_ready is high
// input stalls only on a completing byte while the previous codeword's bytes still wait
// reset: synchronous active low, clears gathered bits, packing state and correction count
module hamming_31_26_byte_stream_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [hcd_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic                        i_packet_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hcd_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_frame_corrected,
    output logic [hcd_pkg::CTR_W-1:0]   o_correction_total,
    output logic                        o_last_of_run
);

    logic            will_complete;
    logic            buf_free;
    logic            load;
    logic            accept;
    hcd_pkg::t_burst burst;

    // bytes that finish no codeword never wait on the output side
    assign o_in_ready = !will_complete || buf_free;
    assign accept     = i_in_valid && o_in_ready;

    hcd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_rx_byte       (i_rx_byte),
        .i_packet_end    (i_packet_end),
        .o_will_complete (will_complete),
        .o_load          (load),
        .o_burst         (burst)
    );

    hcd_out_buf u_out_buf (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (load),
        .i_burst            (burst),
        .o_free             (buf_free),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_frame_corrected  (o_frame_corrected),
        .o_correction_total (o_correction_total),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

// ===== rtl/hcd_checker.sv =====
// port level checks for the hamming byte stream decoder, bound to the top level
`include "hamming_31_26_byte_stream_decoder_defines.svh"

module hcd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [hcd_pkg::BYTE_W-1:0]  o_out_byte,
    input logic                        o_frame_corrected,
    input logic [hcd_pkg::CTR_W-1:0]   o_correction_total,
    input logic                        o_last_of_run
);

    // stalled result holds
    `HCD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte), "stalled output byte changed")

    // a transfer that is not the last of its run leaves more bytes behind
    `HCD_ASSERT_NEXT(a_run_continues, o_out_valid && i_out_ready && !o_last_of_run, o_out_valid, "run ended without last_of_run")

    // bytes of one codeword share their status
    `HCD_ASSERT_NEXT(a_run_status, o_out_valid && i_out_ready && !o_last_of_run, $stable(o_correction_total) && $stable(o_frame_corrected), "status changed inside a run")

    // a corrected codeword has been counted
    `HCD_ASSERT_NOW(a_corr_counted, o_out_valid && o_frame_corrected, o_correction_total != '0, "correction not counted")

endmodule

bind hamming_31_26_byte_stream_decoder hcd_checker u_hcd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_out_byte         (o_out_byte),
    .o_frame_corrected  (o_frame_corrected),
    .o_correction_total (o_correction_total),
    .o_last_of_run      (o_last_of_run)
);
